// ----- src/assert_macros.svh -----
// Assertion macros for the checker file.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, for a condition that must never hold at an edge out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- src/btm_pkg.sv -----
// Package for the bundle template matcher: sizes, opcodes, FSM states
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package btm_pkg;

	localparam int SLOTS     = 3;
	localparam int TEMPLATES = 32;
	localparam int PROP_BITS = 8;

	localparam int SLOT_W   = 2;
	localparam int TIDX_IN_W = 5;
	localparam int TIDX_W   = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1;
	localparam int ENTRY_W  = PROP_BITS + 1;
	localparam int MASK_W   = SLOTS * PROP_BITS;

	localparam int OP_W       = 3;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_PAY_W  = 9 + MASK_W;
	localparam int OUT_DATA_W = ((OUT_PAY_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR    = 3'd0,
		OP_LOAD     = 3'd1,
		OP_RESERVE  = 3'd2,
		OP_SET_STOP = 3'd3,
		OP_CLR_STOP = 3'd4,
		OP_TRY_SLOT = 3'd5,
		OP_TRY_STOP = 3'd6,
		OP_STATUS   = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic scan;
		logic out_load;
	} btm_cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    slot_bad;
		logic    scan_done;
	} btm_stat_t;

endpackage

// ----- src/btm_datapath.sv -----
// Datapath: command register, bundle state, per-slot template memories,
// template compare and the result register. Depends on btm_pkg.
`timescale 1ns / 1ps

module btm_datapath import btm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  opcode_t              in_op,
	input  logic [SLOT_W-1:0]    in_slot,
	input  logic [PROP_BITS-1:0] in_prop,
	input  logic [TIDX_IN_W-1:0] in_tidx,
	input  logic                 in_stop,
	input  btm_cmd_t             cmd,
	output btm_stat_t            stat,
	output logic                 answer,
	output logic                 slot_error,
	output logic [TIDX_IN_W-1:0] template_code,
	output logic                 bundle_full,
	output logic                 bundle_empty,
	output logic [MASK_W-1:0]    packed_mask
);

	opcode_t              op_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [PROP_BITS-1:0] prop_q;
	logic [TIDX_IN_W-1:0] tidx_q;
	logic                 stop_q;

	logic [SLOTS-1:0]     used_q;
	logic [SLOTS-1:0]     sstop_q;
	logic [PROP_BITS-1:0] uprop_q [SLOTS];
	logic [TIDX_W-1:0]    chosen_q;
	logic [MASK_W-1:0]    pack_q;
	logic                 answer_q;
	logic                 err_q;

	logic [TIDX_W-1:0]    addr_q;
	logic [TIDX_W-1:0]    addr_s1;
	logic                 rd_vld_s1;
	logic [ENTRY_W-1:0]   rd_s1 [SLOTS];

	logic                 bad;
	logic                 load_ok;
	logic                 overlap;
	logic                 match;
	logic                 last;
	logic [MASK_W-1:0]    pack_add;

	function automatic logic fits(input logic [PROP_BITS-1:0] p,
		input logic [PROP_BITS-1:0] need);
		return (p == '0) || ((p & need) == need);
	endfunction

	assign bad = (op_q != OP_CLEAR) && (op_q != OP_STATUS) && (int'(slot_q) >= SLOTS);
	assign load_ok = int'(tidx_q) < TEMPLATES;
	assign last = addr_s1 == TIDX_W'(TEMPLATES - 1);

	always_comb begin
		overlap  = 1'b0;
		pack_add = '0;
		for (int j = 0; j < SLOTS; j++) begin
			if ((uprop_q[j] & prop_q) != '0)
				overlap = 1'b1;
			if (SLOT_W'(j) == slot_q)
				pack_add[(SLOTS - 1 - j) * PROP_BITS +: PROP_BITS] = prop_q;
		end
	end

	// Compare the template entry just read against the bundle.
	always_comb begin
		logic [PROP_BITS-1:0] tp;
		logic                 ts;
		logic [PROP_BITS-1:0] p;
		logic                 sel;
		logic                 sb;
		match = 1'b1;
		for (int j = 0; j < SLOTS; j++) begin
			tp  = rd_s1[j][PROP_BITS-1:0];
			ts  = rd_s1[j][PROP_BITS];
			sel = SLOT_W'(j) == slot_q;
			p   = sel ? prop_q : uprop_q[j];
			sb  = sel ? 1'b1 : sstop_q[j];
			if (op_q == OP_TRY_SLOT) begin
				if (sel || used_q[j] || sstop_q[j]) begin
					if (!fits(p, tp) || (sstop_q[j] != ts))
						match = 1'b0;
				end
			end else begin
				if (ts != sb)
					match = 1'b0;
				else if (used_q[j] && !fits(uprop_q[j], tp))
					match = 1'b0;
			end
		end
	end

	assign stat.op        = op_q;
	assign stat.slot_bad  = bad;
	assign stat.scan_done = rd_vld_s1 && (match || last);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= in_op;
			slot_q <= in_slot;
			prop_q <= in_prop;
			tidx_q <= in_tidx;
			stop_q <= in_stop;
		end
	end

	// One memory per slot, indexed by template number.
	for (genvar j = 0; j < SLOTS; j++) begin : g_mem
		logic [ENTRY_W-1:0] mem [TEMPLATES];
		logic               wr;

		assign wr = cmd.exec && !bad && (op_q == OP_LOAD) && load_ok &&
			(SLOT_W'(j) == slot_q);

		always_ff @(posedge clk) begin
			if (wr)
				mem[tidx_q[TIDX_W-1:0]] <= {stop_q, prop_q};
			if (cmd.scan)
				rd_s1[j] <= mem[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			sstop_q   <= '0;
			chosen_q  <= '0;
			pack_q    <= '0;
			rd_vld_s1 <= 1'b0;
			for (int j = 0; j < SLOTS; j++)
				uprop_q[j] <= '0;
		end else begin
			rd_vld_s1 <= cmd.scan;
			if (cmd.exec && !bad) begin
				case (op_q)
					OP_CLEAR: begin
						used_q   <= '0;
						sstop_q  <= '0;
						chosen_q <= '0;
						pack_q   <= '0;
						for (int j = 0; j < SLOTS; j++)
							uprop_q[j] <= '0;
					end
					OP_RESERVE: begin
						for (int j = 0; j < SLOTS; j++) begin
							if (SLOT_W'(j) == slot_q) begin
								used_q[j]  <= 1'b1;
								uprop_q[j] <= prop_q;
							end
						end
						pack_q <= pack_q | pack_add;
					end
					OP_SET_STOP: begin
						for (int j = 0; j < SLOTS; j++)
							if (SLOT_W'(j) == slot_q)
								sstop_q[j] <= 1'b1;
					end
					OP_CLR_STOP: begin
						for (int j = 0; j < SLOTS; j++)
							if (SLOT_W'(j) == slot_q)
								sstop_q[j] <= 1'b0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.scan && rd_vld_s1 && match)
				chosen_q <= addr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			addr_q   <= '0;
			err_q    <= bad;
			answer_q <= !bad && (op_q == OP_STATUS) && overlap;
		end
		if (cmd.scan) begin
			addr_q  <= addr_q + 1'b1;
			addr_s1 <= addr_q;
			if (rd_vld_s1 && match)
				answer_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			answer        <= answer_q;
			slot_error    <= err_q;
			template_code <= TIDX_IN_W'(chosen_q);
			bundle_full   <= &used_q;
			bundle_empty  <= ~|used_q;
			packed_mask   <= pack_q;
		end
	end

endmodule

// ----- src/btm_ctrl.sv -----
// Controller: sequences capture, execute, template scan and result load,
// and owns the handshake flags. Depends on btm_pkg.
`timescale 1ns / 1ps

module btm_ctrl import btm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  btm_stat_t stat,
	output btm_cmd_t  cmd
);

	state_t state_q;
	state_t state_nx;
	logic   out_valid_q;
	logic   is_try;
	logic   out_free;

	assign is_try   = (stat.op == OP_TRY_SLOT) || (stat.op == OP_TRY_STOP);
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_nx = ST_EXEC;
			end
			ST_EXEC: begin
				state_nx = (is_try && !stat.slot_bad) ? ST_SCAN : ST_FINISH;
			end
			ST_SCAN: begin
				if (stat.scan_done)
					state_nx = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC:   cmd.exec = 1'b1;
			ST_SCAN:   cmd.scan = 1'b1;
			ST_FINISH: cmd.out_load = out_free;
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- src/bundle_template_matcher_top.sv -----
// Top level of the bundle template matcher: stream ports, controller and
// datapath. Depends on btm_pkg, btm_ctrl and btm_datapath.
`timescale 1ns / 1ps
//
// Commands arrive on the s_ stream, one item per command; each command gives
// exactly one result item on the m_ stream, in order.
// The block works on one command at a time. s_tready is high only while idle.
// A command other than a try, and a try whose slot is out of range, passes from
// the execute state to the finish state, which loads its result into the output
// register behind m_tvalid; the block then returns to idle.
// A try with its slot in range reads the template memories one template per cycle,
// from template 0 upward, and stops at the first fit or after the last template.
// The block takes no new command until the scan and its finish state are done.
// That one-read-per-cycle scan of the template memories sets the rate.
// The result sits in an output register; the next command is accepted while it
// waits. If the receiver still holds off the old result when a new one is done,
// the block waits in its finish state until m_tready frees the register.
// Reset clears the bundle, the chosen template and the handshake state.
// Template memories are not cleared; a template must be loaded before a try
// reads it.
//
module bundle_template_matcher_top import btm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// slot, property_req, template_index, stop_flag
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// opcode
	input  logic [OP_W-1:0]       s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// answer, slot_error, template_code, bundle_full, bundle_empty, packed_mask, zero pad
	output logic [OUT_DATA_W-1:0] m_tdata
);

	btm_cmd_t             cmd;
	btm_stat_t            stat;
	logic                 answer;
	logic                 slot_error;
	logic [TIDX_IN_W-1:0] template_code;
	logic                 bundle_full;
	logic                 bundle_empty;
	logic [MASK_W-1:0]    packed_mask;

	btm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	btm_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_op         (opcode_t'(s_tuser)),
		.in_slot       (s_tdata[SLOT_W-1:0]),
		.in_prop       (s_tdata[SLOT_W +: PROP_BITS]),
		.in_tidx       (s_tdata[SLOT_W + PROP_BITS +: TIDX_IN_W]),
		.in_stop       (s_tdata[SLOT_W + PROP_BITS + TIDX_IN_W]),
		.cmd           (cmd),
		.stat          (stat),
		.answer        (answer),
		.slot_error    (slot_error),
		.template_code (template_code),
		.bundle_full   (bundle_full),
		.bundle_empty  (bundle_empty),
		.packed_mask   (packed_mask)
	);

	assign m_tdata = {{(OUT_DATA_W - OUT_PAY_W){1'b0}}, packed_mask, bundle_empty,
		bundle_full, template_code, slot_error, answer};

endmodule

// ----- src/btm_checker.sv -----
// Port-level checker for the bundle template matcher, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module btm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// A stalled result keeps its payload.
	`ASSERT_CLK(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

	// One command at a time: the block is busy right after an acceptance.
	`ASSERT_CLK(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready |=> !s_tready, "accepted an item while busy")

	// An ignored command never reports a found template or an overlap.
	`ASSERT_NEVER(a_err_no_answer, clk, arst_n, m_tvalid && m_tdata[0] && m_tdata[1], "answer set on slot error")

	// A bundle with slots is never both full and empty.
	`ASSERT_NEVER(a_full_empty, clk, arst_n, m_tvalid && m_tdata[7] && m_tdata[8], "bundle full and empty")

endmodule

bind bundle_template_matcher_top btm_checker u_btm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
